// ----- rtl/core/motor_servo_pwm_command_mapper_unit_macros.svh -----
// Assertion macros for the servo and motor PWM command mapper.
// Included by the top level; depends on nothing else.
`ifndef MOTOR_SERVO_PWM_COMMAND_MAPPER_UNIT_MACROS_SVH
`define MOTOR_SERVO_PWM_COMMAND_MAPPER_UNIT_MACROS_SVH

// Implication in the same cycle, checked outside reset.
`define MSPCM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle, checked outside reset.
`define MSPCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/mspcm_pkg.sv -----
// Shared types, constants and channel tables for the PWM command mapper.
// No dependencies; every RTL module imports this package.
`default_nettype none

package mspcm_pkg;

   typedef enum logic [1:0] {
      KIND_MOTOR        = 2'd0,
      KIND_SERVO_STD    = 2'd1,
      KIND_SERVO_NARROW = 2'd2,
      KIND_PULSE        = 2'd3
   } kind_type;

   localparam int ChanWidth  = 4;
   localparam int OffWidth   = 12;
   localparam int IdWidth    = 8;
   localparam int ValueWidth = 16;
   localparam int NumWidth   = 17;

   localparam int SpeedLimit   = 100;
   localparam int AngleMax     = 180;
   localparam int PulseMax     = 20000;
   localparam int StdBaseUs    = 500;
   localparam int NarrowBaseUs = 1000;

   // 4095/100 reduces to 819/20, 2000/180 to 100/9 and 1000/180 to 50/9.
   localparam int MotorScale  = 819;
   localparam int StdScale    = 100;
   localparam int NarrowScale = 50;

   // Reciprocals, rounded up, exact over the operand ranges used here.
   localparam int Recip20      = 104858;
   localparam int Recip20Shift = 21;
   localparam int Recip9       = 29128;
   localparam int Recip9Shift  = 18;
   // 128/625 scaled by 2**23, rounded up.
   localparam int TickRecip    = 1717987;
   localparam int TickShift    = 23;

   // The meaning of num changes from stage to stage: clamped operand, scaled
   // product, quotient or pulse width, and finally the off count.
   typedef struct packed {
      kind_type               kind;
      logic [ChanWidth-1:0]   ch_first;
      logic [ChanWidth-1:0]   ch_second;
      logic                   neg;
      logic [NumWidth-1:0]    num;
   } item_type;

   function automatic logic [ChanWidth-1:0] pair_first(input logic [1:0] idx);
      logic [ChanWidth-1:0] ch;
      unique case (idx)
         2'd0: ch = 4'd0;
         2'd1: ch = 4'd2;
         2'd2: ch = 4'd5;
         default: ch = 4'd7;
      endcase
      return ch;
   endfunction

   function automatic logic [ChanWidth-1:0] pair_second(input logic [1:0] idx);
      logic [ChanWidth-1:0] ch;
      unique case (idx)
         2'd0: ch = 4'd1;
         2'd1: ch = 4'd3;
         2'd2: ch = 4'd4;
         default: ch = 4'd6;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mspcm_decode.sv -----
// First pipeline stage: command decode, target check and operand clamping.
// Depends on mspcm_pkg.
`default_nettype none

module mspcm_decode
   import mspcm_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         hold,
   input  wire logic                         start,
   input  wire logic [1:0]                   req_type,
   input  wire logic [IdWidth-1:0]           req_target_id,
   input  wire logic signed [ValueWidth-1:0] req_value,
   output      logic                         valid,
   output      item_type                     item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   kind_type kind;
   logic     id_motor_ok;
   logic     id_chan_ok;
   logic [1:0] pair_idx;

   always_comb begin
      kind        = kind_type'(req_type);
      id_motor_ok = (req_target_id >= 8'd1) && (req_target_id <= 8'd4);
      id_chan_ok  = (req_target_id[7:4] == 4'd0);
      pair_idx    = 2'(req_target_id[1:0] - 2'd1);

      item_in           = '0;
      item_in.kind      = kind;
      item_in.ch_first  = req_target_id[3:0];
      item_in.ch_second = req_target_id[3:0];
      valid_in          = 1'b0;

      unique case (kind) inside
         KIND_MOTOR: begin
            valid_in          = start && id_motor_ok;
            item_in.ch_first  = pair_first(pair_idx);
            item_in.ch_second = pair_second(pair_idx);
            item_in.neg       = req_value[ValueWidth-1];
            if (req_value > $signed(16'(SpeedLimit))) begin
               item_in.num = 17'(SpeedLimit);
            end else if (req_value < $signed(-16'(SpeedLimit))) begin
               item_in.num = 17'(SpeedLimit);
            end else if (req_value[ValueWidth-1]) begin
               item_in.num = 17'((-req_value) & 16'h007F);
            end else begin
               item_in.num = 17'(req_value[6:0]);
            end
         end
         KIND_SERVO_STD, KIND_SERVO_NARROW: begin
            valid_in = start && id_chan_ok;
            if (req_value[ValueWidth-1]) begin
               item_in.num = '0;
            end else if (req_value > $signed(16'(AngleMax))) begin
               item_in.num = 17'(AngleMax);
            end else begin
               item_in.num = 17'(req_value[7:0]);
            end
         end
         default: begin
            valid_in = start && id_chan_ok;
            if (req_value[ValueWidth-1]) begin
               item_in.num = '0;
            end else if (req_value > $signed(16'(PulseMax))) begin
               item_in.num = 17'(PulseMax);
            end else begin
               item_in.num = 17'(req_value[14:0]);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!hold) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         item_ff <= item_in;
      end
   end

   assign valid = valid_ff;
   assign item  = item_ff;

endmodule

`default_nettype wire

// ----- rtl/core/mspcm_scale.sv -----
// Stages two to four: constant scaling, reciprocal division and servo offset.
// Depends on mspcm_pkg.
`default_nettype none

module mspcm_scale
   import mspcm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     hold,
   input  wire logic     in_valid,
   input  wire item_type in_item,
   output      logic     out_valid,
   output      item_type out_item
);

   logic     mul_valid_ff, div_valid_ff, add_valid_ff;
   item_type mul_item_ff, mul_item_in;
   item_type div_item_ff, div_item_in;
   item_type add_item_ff, add_item_in;
   logic [33:0] motor_recip;
   logic [29:0] servo_recip;

   // Scale by the reduced numerator of each command type.
   always_comb begin
      mul_item_in = in_item;
      case (in_item.kind)
         KIND_MOTOR:        mul_item_in.num = 17'(in_item.num[6:0]) * 17'(MotorScale);
         KIND_SERVO_STD:    mul_item_in.num = 17'(in_item.num[7:0]) * 17'(StdScale);
         KIND_SERVO_NARROW: mul_item_in.num = 17'(in_item.num[7:0]) * 17'(NarrowScale);
         default:           mul_item_in.num = in_item.num;
      endcase
   end

   // Divide by 20 (motor) or 9 (servo) through a rounded-up reciprocal.
   always_comb begin
      motor_recip = 34'(mul_item_ff.num) * 34'(Recip20);
      servo_recip = 30'(mul_item_ff.num[14:0]) * 30'(Recip9);
      div_item_in = mul_item_ff;
      case (mul_item_ff.kind) inside
         KIND_MOTOR:
            div_item_in.num = 17'(motor_recip[Recip20Shift +: OffWidth]);
         KIND_SERVO_STD, KIND_SERVO_NARROW:
            div_item_in.num = 17'(servo_recip[Recip9Shift +: 11]);
         default:
            div_item_in.num = mul_item_ff.num;
      endcase
   end

   // Add the pulse base of the servo range.
   always_comb begin
      add_item_in = div_item_ff;
      case (div_item_ff.kind)
         KIND_SERVO_STD:    add_item_in.num = div_item_ff.num + 17'(StdBaseUs);
         KIND_SERVO_NARROW: add_item_in.num = div_item_ff.num + 17'(NarrowBaseUs);
         default:           add_item_in.num = div_item_ff.num;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         div_valid_ff <= 1'b0;
         add_valid_ff <= 1'b0;
      end else if (!hold) begin
         mul_valid_ff <= in_valid;
         div_valid_ff <= mul_valid_ff;
         add_valid_ff <= div_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         mul_item_ff <= mul_item_in;
         div_item_ff <= div_item_in;
         add_item_ff <= add_item_in;
      end
   end

   assign out_valid = add_valid_ff;
   assign out_item  = add_item_ff;

endmodule

`default_nettype wire

// ----- rtl/core/mspcm_ticks.sv -----
// Stage five: pulse width in microseconds to 12-bit off count.
// Depends on mspcm_pkg.
`default_nettype none

module mspcm_ticks
   import mspcm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     hold,
   input  wire logic     in_valid,
   input  wire item_type in_item,
   output      logic     out_valid,
   output      item_type out_item
);

   logic        valid_ff;
   item_type    item_ff, item_in;
   logic [35:0] tick_prod;

   // Ticks are floor(us * 128 / 625); keeping only twelve bits masks the count.
   always_comb begin
      tick_prod = 36'(in_item.num[14:0]) * 36'(TickRecip);
      item_in   = in_item;
      if (in_item.kind != KIND_MOTOR) begin
         item_in.num = 17'(tick_prod[TickShift +: OffWidth]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!hold) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// ----- rtl/core/mspcm_emit.sv -----
// Output stage: shows one write per cycle and splits motor commands in two.
// Depends on mspcm_pkg.
`default_nettype none

module mspcm_emit
   import mspcm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire item_type             in_item,
   output      logic                 hold,
   output      logic                 rsp_strobe,
   output      logic [ChanWidth-1:0] rsp_channel,
   output      logic [OffWidth-1:0]  rsp_off_count,
   output      logic                 rsp_last_write
);

   logic     valid_ff;
   logic     second_ff, second_in;
   item_type item_ff;
   logic     motor;
   logic [OffWidth-1:0] duty;

   assign motor = (item_ff.kind == KIND_MOTOR);
   assign duty  = item_ff.num[OffWidth-1:0];

   // The first half of a motor command keeps the whole pipeline in place.
   assign hold      = valid_ff && motor && !second_ff;
   assign second_in = hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
         if (!hold) begin
            valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         item_ff <= in_item;
      end
   end

   always_comb begin
      rsp_strobe     = valid_ff;
      rsp_last_write = !motor || second_ff;
      if (second_ff) begin
         rsp_channel   = item_ff.ch_second;
         rsp_off_count = item_ff.neg ? duty : '0;
      end else begin
         rsp_channel   = item_ff.ch_first;
         rsp_off_count = (motor && item_ff.neg) ? '0 : duty;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/motor_servo_pwm_command_mapper_unit.sv -----
// Top level of the motor and servo PWM command mapper.
// Depends on mspcm_pkg, mspcm_decode, mspcm_scale, mspcm_ticks, mspcm_emit and
// the assertion macro header.
//
//   Channel    Ports                                       Handshake
//   request    req_type, req_target_id, req_value          start high, busy low
//   result     rsp_channel, rsp_off_count, rsp_last_write  rsp_strobe, one cycle
//
// A request is taken at any clock edge at which start is high and busy is low.
// Its first result is shown once it has passed six registers: decode, scaling,
// reciprocal division, servo offset, tick conversion and the output register.
// Servo and raw pulse requests give at most one result and run at one request
// per cycle while no motor request holds the pipeline. A motor request gives
// two results through the single result port, so busy is high for the one
// cycle in which its first write is shown, and the whole pipeline holds in
// place for that cycle.
// Reset is synchronous and clears every valid bit; the receiver cannot stall.
`default_nettype none

`include "motor_servo_pwm_command_mapper_unit_macros.svh"

module motor_servo_pwm_command_mapper_unit
   import mspcm_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output      logic                         busy,
   input  wire logic [1:0]                   req_type,
   input  wire logic [IdWidth-1:0]           req_target_id,
   input  wire logic signed [ValueWidth-1:0] req_value,
   output      logic                         rsp_strobe,
   output      logic [ChanWidth-1:0]         rsp_channel,
   output      logic [OffWidth-1:0]          rsp_off_count,
   output      logic                         rsp_last_write
);

   logic     hold;
   logic     dec_valid, scl_valid, tck_valid;
   item_type dec_item, scl_item, tck_item;

   // Requests are refused only while a motor request shows its first write.
   assign busy = hold;

   mspcm_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .hold          (hold),
      .start         (start),
      .req_type      (req_type),
      .req_target_id (req_target_id),
      .req_value     (req_value),
      .valid         (dec_valid),
      .item          (dec_item)
   );

   mspcm_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .hold      (hold),
      .in_valid  (dec_valid),
      .in_item   (dec_item),
      .out_valid (scl_valid),
      .out_item  (scl_item)
   );

   mspcm_ticks u_ticks (
      .clock     (clock),
      .reset     (reset),
      .hold      (hold),
      .in_valid  (scl_valid),
      .in_item   (scl_item),
      .out_valid (tck_valid),
      .out_item  (tck_item)
   );

   mspcm_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (tck_valid),
      .in_item        (tck_item),
      .hold           (hold),
      .rsp_strobe     (rsp_strobe),
      .rsp_channel    (rsp_channel),
      .rsp_off_count  (rsp_off_count),
      .rsp_last_write (rsp_last_write)
   );

   // While busy, the first of two motor writes is on the result ports.
   `MSPCM_ASSERT_SAME(a_busy_first_write, clock, reset, busy, rsp_strobe && !rsp_last_write && !rsp_channel[3], "busy without a first motor write on the result ports")
   // The second motor write always follows in the very next cycle.
   `MSPCM_ASSERT_NEXT(a_busy_then_last, clock, reset, busy, rsp_strobe && rsp_last_write && !busy, "second motor write did not follow the first")
   // Only the first half of a motor request is ever shown without last_write.
   `MSPCM_ASSERT_SAME(a_first_needs_busy, clock, reset, rsp_strobe && !rsp_last_write, busy, "first write shown while the pipeline kept moving")

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for motor_servo_pwm_command_mapper_unit.
// Needs only the RTL and mspcm_pkg; a small ledger class predicts the PWM
// channel writes and the tasks below drive requests under random idling.
`timescale 1ns / 1ps

module tb;
   import mspcm_pkg::*;

   // Run-time bounds.
   localparam int CycleLimit   = 200000;
   localparam int ItemsPerPass = 600;
   localparam int DrainCycles  = 12;

   // Scaling constants of the mapping, written out on the testbench side.
   localparam int SpeedMax    = 100;
   localparam int DutyFull    = 4095;
   localparam int AngleTop    = 180;
   localparam int PulseTop    = 20000;
   localparam int StdFloorUs  = 500;
   localparam int StdRangeUs  = 2000;
   localparam int NarFloorUs  = 1000;
   localparam int NarRangeUs  = 1000;
   localparam int LastChannel = 15;

   // One PWM channel write as the block presents it.
   typedef struct {
      logic [ChanWidth-1:0] channel;
      logic [OffWidth-1:0]  off_count;
      logic                 last_write;
   } pwm_write_type;

   // The ledger turns each accepted request into the channel writes it should
   // cause and checks the writes that come out, strictly in order.
   class pwm_write_ledger;
      pwm_write_type awaited[$];
      int            mismatches;

      function new();
         mismatches = 0;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10)
            $display("%s", msg);
      endfunction

      function void push_write(int ch, int off, bit last);
         pwm_write_type w;
         w.channel    = ch[ChanWidth-1:0];
         w.off_count  = off[OffWidth-1:0];
         w.last_write = last;
         awaited.push_back(w);
      endfunction

      function void note_command(kind_type kind, logic [IdWidth-1:0] id,
                                 logic signed [ValueWidth-1:0] value);
         int v;
         int duty;
         int lead_ch;
         int trail_ch;
         int us;
         v = value;
         if (kind == KIND_MOTOR) begin
            if (id < 1 || id > 4)
               return;
            if (v > SpeedMax)
               v = SpeedMax;
            if (v < -SpeedMax)
               v = -SpeedMax;
            duty = ((v < 0) ? -v : v) * DutyFull / SpeedMax;
            case (id)
               1: begin lead_ch = 0; trail_ch = 1; end
               2: begin lead_ch = 2; trail_ch = 3; end
               3: begin lead_ch = 5; trail_ch = 4; end
               default: begin lead_ch = 7; trail_ch = 6; end
            endcase
            push_write(lead_ch, (v > 0) ? duty : 0, 1'b0);
            push_write(trail_ch, (v < 0) ? duty : 0, 1'b1);
            return;
         end
         if (kind != KIND_PULSE) begin
            if (v < 0)
               v = 0;
            if (v > AngleTop)
               v = AngleTop;
         end
         case (kind)
            KIND_SERVO_STD:    us = StdFloorUs + v * StdRangeUs / AngleTop;
            KIND_SERVO_NARROW: us = NarFloorUs + v * NarRangeUs / AngleTop;
            default:           us = v;
         endcase
         if (id > LastChannel)
            return;
         if (us < 0)
            us = 0;
         if (us > PulseTop)
            us = PulseTop;
         // The off count keeps only twelve bits, so a full frame wraps to zero.
         push_write(id, (us * 128 / 625) & 32'hFFF, 1'b1);
      endfunction

      function void check_write(logic [ChanWidth-1:0] ch, logic [OffWidth-1:0] off,
                                logic last);
         pwm_write_type w;
         if (awaited.size() == 0) begin
            flag($sformatf("unexpected write: ch %0d off %0d last %0d", ch, off, last));
            return;
         end
         w = awaited.pop_front();
         if (ch !== w.channel || off !== w.off_count || last !== w.last_write)
            flag($sformatf("write mismatch: expected ch %0d off %0d last %0d, got ch %0d off %0d last %0d",
                           w.channel, w.off_count, w.last_write, ch, off, last));
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [1:0]                   req_type = 2'd0;
   logic [IdWidth-1:0]           req_target_id = '0;
   logic signed [ValueWidth-1:0] req_value = '0;
   logic                         rsp_strobe;
   logic [ChanWidth-1:0]         rsp_channel;
   logic [OffWidth-1:0]          rsp_off_count;
   logic                         rsp_last_write;

   pwm_write_ledger ledger = new();
   int              cycle_count = 0;

   motor_servo_pwm_command_mapper_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_target_id  (req_target_id),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_channel    (rsp_channel),
      .rsp_off_count  (rsp_off_count),
      .rsp_last_write (rsp_last_write)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Both monitors sit in one block so that a request is always noted before
   // any write it could cause is checked. Everything here samples the values
   // that stood before the edge, since the drivers use nonblocking updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && busy === 1'b0)
            ledger.note_command(kind_type'(req_type), req_target_id, req_value);
         if (rsp_strobe === 1'b1)
            ledger.check_write(rsp_channel, rsp_off_count, rsp_last_write);
      end
   end

   // Watchdog: a run that hangs or crawls ends here as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("** motor_servo_pwm_command_mapper_unit: FAILED **");
         $finish;
      end
   end

   // Presents one request and holds it until the block takes it, that is
   // until an edge at which busy is low. On return start is still high, so a
   // following request goes straight on without a bubble.
   task automatic issue_request(input kind_type kind, input logic [IdWidth-1:0] id,
                                input logic signed [ValueWidth-1:0] value);
      start         <= 1'b1;
      req_type      <= kind;
      req_target_id <= id;
      req_value     <= value;
      do
         @(posedge clock);
      while (busy !== 1'b0);
   endtask

   // Idle cycles after a request, each drawn on its own, so that gaps land on
   // every phase of the pipeline and on the cycle in which busy is high. The
   // request fields carry noise while start is low; the block must ignore it.
   task automatic idle_between(input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start         <= 1'b0;
         req_type      <= 2'($urandom_range(3));
         req_target_id <= 8'($urandom_range(255));
         req_value     <= 16'($urandom_range(16'hFFFF));
         @(posedge clock);
      end
   endtask

   // Mostly well-formed requests: motor numbers and servo channels in range,
   // speeds and angles around their clamping limits and pulse widths over the
   // whole frame. About one in eight targets and values is drawn from the full
   // field so that every bit of each field toggles.
   task automatic random_request(input int idle_pct);
      kind_type                     kind;
      logic [IdWidth-1:0]           id;
      logic signed [ValueWidth-1:0] value;
      kind = kind_type'($urandom_range(3));
      if ($urandom_range(99) < 12)
         id = 8'($urandom_range(255));
      else if (kind == KIND_MOTOR)
         id = 8'($urandom_range(4, 1));
      else
         id = 8'($urandom_range(LastChannel));
      if ($urandom_range(99) < 12)
         value = 16'($urandom_range(16'hFFFF));
      else
         case (kind)
            KIND_MOTOR: value = 16'(int'($urandom_range(240)) - 120);
            KIND_PULSE: value = 16'(int'($urandom_range(PulseTop + 200)) - 100);
            default:    value = 16'(int'($urandom_range(AngleTop + 40)) - 20);
         endcase
      issue_request(kind, id, value);
      idle_between(idle_pct);
   endtask

   initial begin
      int idle_plan[3];
      idle_plan = '{23, 66, 0};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests, back to back. Motors: every pair, both full speeds,
      // zero, speeds beyond the clamp, the smallest speeds and the unknown
      // motor numbers either side of the valid range.
      issue_request(KIND_MOTOR, 8'd1, 16'sd100);
      issue_request(KIND_MOTOR, 8'd2, -16'sd100);
      issue_request(KIND_MOTOR, 8'd3, 16'sd0);
      issue_request(KIND_MOTOR, 8'd4, 16'sd32767);
      issue_request(KIND_MOTOR, 8'd4, -16'sd32768);
      issue_request(KIND_MOTOR, 8'd1, 16'sd1);
      issue_request(KIND_MOTOR, 8'd3, -16'sd1);
      issue_request(KIND_MOTOR, 8'd0, 16'sd50);
      issue_request(KIND_MOTOR, 8'd5, 16'sd50);
      issue_request(KIND_MOTOR, 8'd255, -16'sd50);
      // Servo angles below, at and above the clamping limits, with the first
      // and last channels and channels just outside the valid range.
      issue_request(KIND_SERVO_STD, 8'd0, -16'sd1);
      issue_request(KIND_SERVO_STD, 8'd15, 16'sd0);
      issue_request(KIND_SERVO_STD, 8'd7, 16'sd180);
      issue_request(KIND_SERVO_STD, 8'd16, 16'sd90);
      issue_request(KIND_SERVO_STD, 8'd3, 16'sd32767);
      issue_request(KIND_SERVO_NARROW, 8'd1, 16'sd181);
      issue_request(KIND_SERVO_NARROW, 8'd14, -16'sd32768);
      issue_request(KIND_SERVO_NARROW, 8'd9, 16'sd90);
      issue_request(KIND_SERVO_NARROW, 8'd255, 16'sd45);
      // Raw pulses: zero, the full frame that wraps to zero, just under it,
      // negative and oversized widths, and a channel out of range.
      issue_request(KIND_PULSE, 8'd0, 16'sd0);
      issue_request(KIND_PULSE, 8'd15, 16'sd20000);
      issue_request(KIND_PULSE, 8'd2, 16'sd19999);
      issue_request(KIND_PULSE, 8'd6, -16'sd1);
      issue_request(KIND_PULSE, 8'd11, 16'sd32767);
      issue_request(KIND_PULSE, 8'd16, 16'sd1000);

      // Random requests in three passes: a lightly idling sender, a heavily
      // idling one, and then requests on every cycle the block allows.
      foreach (idle_plan[p])
         repeat (ItemsPerPass) random_request(idle_plan[p]);
      start <= 1'b0;

      // Let the pipeline drain, then watch a little longer for stray writes.
      while (ledger.awaited.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (ledger.mismatches == 0 && ledger.awaited.size() == 0)
         $display("** motor_servo_pwm_command_mapper_unit: PASSED **");
      else
         $display("** motor_servo_pwm_command_mapper_unit: FAILED **");
      $finish;
   end

endmodule
